@@ design/fsi_pkg.sv @@
// ----------------------------------------------------------------------------
// fsi_pkg
// Shared types, constants and elaboration-time coefficient functions for the
// Fresnel sine integral pipeline.
// ----------------------------------------------------------------------------
package fsi_pkg;

    typedef logic signed [63:0] q64_t;

    // quadrant of the reduced angle
    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    localparam int MUL_LAT      = 2;
    localparam int CELL_LAT     = MUL_LAT + 1;
    localparam int TAYLOR_TERMS = 17;
    localparam int ASYM_TERMS   = 5;
    localparam int CORDIC_STEPS = 32;
    localparam int REDUCE_LAT   = 3;
    localparam int XY_W         = 36;

    // ceil(2^64 / 9), exact floor quotient for dividends below 2^63
    localparam q64_t RECIP9 = 64'sd2049638230412172402;

    localparam logic [63:0] TWO_BY_PI_HI = 64'hA2F9836E4E441529;
    localparam logic [63:0] TWO_BY_PI_LO = 64'hFC2757D1F534DDC0;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam q64_t SQRT_PI_8 = 64'sd672867904;
    localparam q64_t S32_MAX   = 64'sd2147483647;
    localparam q64_t S32_MIN   = -64'sd2147483648;

    // unsigned long division for constant evaluation
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q60 from the alternating series
    function automatic logic [63:0] atan_recip(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] sum;
        p   = udiv(64'd1 << 60, n);
        sum = '0;
        k   = '0;
        while (p != 64'd0)
        begin
            t = udiv(p, 2 * k + 64'd1);
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
            p = udiv(udiv(p, n), n);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // rotation angle of one cordic step, first step is pi/4
    function automatic q64_t cordic_angle(input int i);
        logic [63:0] a;
        if (i == 0)
            a = atan_recip(64'd2) + atan_recip(64'd3);
        else
            a = atan_recip(64'd1 << i);
        return q64_t'(a);
    endfunction

    // taylor coefficient k in Q56
    function automatic q64_t taylor_coef(input int k);
        logic [63:0] g;
        logic [63:0] v;
        g = 64'd1 << 56;
        for (int j = 0; j < k; j++)
            g = udiv(g, 64'((2 * j + 2) * (2 * j + 3))) * 64'd81;
        v = udiv(g, 64'(4 * k + 3));
        return k[0] ? -q64_t'(v) : q64_t'(v);
    endfunction

    // cosine-weight polynomial coefficients in Q46, highest first
    function automatic q64_t pc_coef(input int j);
        q64_t c;
        case (j)
            0:       c = -(64'sd2027025 <<< 37);
            1:       c = 64'sd10395 <<< 39;
            2:       c = -(64'sd105 <<< 41);
            3:       c = 64'sd3 <<< 43;
            default: c = -(64'sd1 <<< 45);
        endcase
        return c;
    endfunction

    // sine-weight polynomial coefficients in Q46, highest first
    function automatic q64_t qs_coef(input int j);
        q64_t c;
        case (j)
            0:       c = -(64'sd34459425 <<< 36);
            1:       c = 64'sd135135 <<< 38;
            2:       c = -(64'sd945 <<< 40);
            3:       c = 64'sd15 <<< 42;
            default: c = -(64'sd1 <<< 44);
        endcase
        return c;
    endfunction

    // magnitude rounding shift, half away from zero
    function automatic q64_t round_shift(input q64_t v, input int s);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? q64_t'(64'd0 - m) : q64_t'(m);
    endfunction

    // input to strobe latency for a given number of fraction bits
    function automatic int latency(input int f);
        int t_pc;
        t_pc = 2 + 62 + 2 * f + MUL_LAT + (ASYM_TERMS - 1) * CELL_LAT;
        return t_pc + 2 * MUL_LAT + 1 + MUL_LAT + 1 + 1;
    endfunction

endpackage

@@ design/fsi_delay.sv @@
// ----------------------------------------------------------------------------
// fsi_delay
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module fsi_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    // shift one tap per cycle
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < N; i++)
            tap_reg[i] <= tap_reg[i-1];
    end

    assign dout = tap_reg[N-1];

endmodule

@@ design/fsi_mulq.sv @@
// ----------------------------------------------------------------------------
// fsi_mulq
// Pipelined signed 64x64 fixed-point multiply, product shifted right by Q,
// truncated toward zero, magnitude saturated to 63 bits.
// ----------------------------------------------------------------------------
module fsi_mulq #(
    parameter int Q = 32
) (
    input  logic         clk,
    input  fsi_pkg::q64_t a,
    input  fsi_pkg::q64_t b,
    output fsi_pkg::q64_t p
);

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic         neg_reg;
    logic [127:0] full;
    logic [63:0]  mag;
    logic         sat;
    fsi_pkg::q64_t p_reg;

    // operand magnitudes
    always_comb
    begin
        ua = a[63] ? (64'd0 - a) : a;
        ub = b[63] ? (64'd0 - b) : b;
    end

    // 32x32 partial products
    always_ff @(posedge clk)
    begin
        pp00_reg <= ua[31:0]  * ub[31:0];
        pp01_reg <= ua[31:0]  * ub[63:32];
        pp10_reg <= ua[63:32] * ub[31:0];
        pp11_reg <= ua[63:32] * ub[63:32];
        neg_reg  <= a[63] ^ b[63];
    end

    // combine, shift and saturate
    always_comb
    begin
        full = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32)
             + ({64'd0, pp10_reg} << 32) + {pp11_reg, 64'd0};
        sat  = |full[127:Q+63];
        mag  = sat ? 64'h7FFF_FFFF_FFFF_FFFF : full[Q+63:Q];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? fsi_pkg::q64_t'(64'd0 - mag) : fsi_pkg::q64_t'(mag);
    end

    assign p = p_reg;

endmodule

@@ design/fsi_horner_cell.sv @@
// ----------------------------------------------------------------------------
// fsi_horner_cell
// One Horner step p*u + c; hands the running value and u to the next cell.
// ----------------------------------------------------------------------------
module fsi_horner_cell #(
    parameter int            Q    = 56,
    parameter fsi_pkg::q64_t COEF = 64'sd0
) (
    input  logic          clk,
    input  fsi_pkg::q64_t p_in,
    input  fsi_pkg::q64_t u_in,
    output fsi_pkg::q64_t p_out,
    output fsi_pkg::q64_t u_out
);

    fsi_pkg::q64_t prod;
    logic [63:0]   u_mid;
    fsi_pkg::q64_t p_out_reg;
    fsi_pkg::q64_t u_out_reg;

    fsi_mulq #(.Q(Q)) u_mul (
        .clk (clk),
        .a   (p_in),
        .b   (u_in),
        .p   (prod)
    );

    fsi_delay #(.W(64), .N(fsi_pkg::MUL_LAT)) u_udly (
        .clk  (clk),
        .din  (u_in),
        .dout (u_mid)
    );

    // add coefficient
    always_ff @(posedge clk)
    begin
        p_out_reg <= prod + COEF;
        u_out_reg <= fsi_pkg::q64_t'(u_mid);
    end

    assign p_out = p_out_reg;
    assign u_out = u_out_reg;

endmodule

@@ design/fsi_div_cell.sv @@
// ----------------------------------------------------------------------------
// fsi_div_cell
// One restoring division step: produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsi_div_cell (
    input  logic        clk,
    input  logic [63:0] rem_in,
    input  logic [63:0] quo_in,
    input  logic [63:0] den_in,
    output logic [63:0] rem_out,
    output logic [63:0] quo_out,
    output logic [63:0] den_out
);

    logic [63:0] rem_sh;
    logic [63:0] rem_next;
    logic [63:0] quo_next;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;

    // shift, compare, subtract
    always_comb
    begin
        rem_sh = {rem_in[62:0], 1'b0};
        if (rem_sh >= den_in)
        begin
            rem_next = rem_sh - den_in;
            quo_next = {quo_in[62:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            quo_next = {quo_in[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_in;
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;

endmodule

@@ design/fsi_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// fsi_cordic_cell
// One rotation-mode CORDIC iteration with a fixed shift and angle.
// ----------------------------------------------------------------------------
module fsi_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic signed [fsi_pkg::XY_W-1:0]   x_in,
    input  logic signed [fsi_pkg::XY_W-1:0]   y_in,
    input  fsi_pkg::q64_t                     z_in,
    output logic signed [fsi_pkg::XY_W-1:0]   x_out,
    output logic signed [fsi_pkg::XY_W-1:0]   y_out,
    output fsi_pkg::q64_t                     z_out
);

    localparam fsi_pkg::q64_t ANGLE = fsi_pkg::cordic_angle(IDX);

    logic signed [fsi_pkg::XY_W-1:0] x_sh;
    logic signed [fsi_pkg::XY_W-1:0] y_sh;
    logic signed [fsi_pkg::XY_W-1:0] x_next;
    logic signed [fsi_pkg::XY_W-1:0] y_next;
    fsi_pkg::q64_t                   z_next;
    logic signed [fsi_pkg::XY_W-1:0] x_reg;
    logic signed [fsi_pkg::XY_W-1:0] y_reg;
    fsi_pkg::q64_t                   z_reg;

    // rotate toward zero residual angle
    always_comb
    begin
        x_sh = x_in >>> IDX;
        y_sh = y_in >>> IDX;
        if (!z_in[63])
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ design/fresnel_sine_integral.sv @@
// ----------------------------------------------------------------------------
// fresnel_sine_integral
// Fresnel sine integral S(x) of a signed fixed-point argument, Q2.30 result.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle, busy stays low
// the latency is set by the reciprocal divider, one quotient bit per cell
// results appear on done for one cycle and cannot be held off
// reset clears the valid pipeline only; no clearing pass is needed
module fresnel_sine_integral #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_value,
    output logic               done,
    output logic signed [31:0] s_value,
    output logic               used_asymptotic
);

    localparam int F      = INPUT_FRAC_BITS;
    localparam int ML     = fsi_pkg::MUL_LAT;
    localparam int NDIV   = 62 + 2 * F;
    localparam int OFF    = 2 + 2 * F;
    localparam int T_X2   = 2;
    localparam int T_W    = T_X2 + ML;
    localparam int T_U    = T_W + ML;
    localparam int T_P    = T_U + (fsi_pkg::TAYLOR_TERMS - 1) * fsi_pkg::CELL_LAT;
    localparam int T_X3   = T_X2 + ML;
    localparam int T_TAY  = T_P + ML + 1;
    localparam int T_R    = T_X2 + NDIV;
    localparam int T_R2   = T_R + ML;
    localparam int T_PC   = T_R2 + (fsi_pkg::ASYM_TERMS - 1) * fsi_pkg::CELL_LAT;
    localparam int T_T    = T_X2 + fsi_pkg::REDUCE_LAT;
    localparam int T_Z    = T_T + ML;
    localparam int T_CR   = T_Z + fsi_pkg::CORDIC_STEPS;
    localparam int T_CS   = T_CR + 1;
    localparam int T_SUM  = T_PC + 2 * ML + 1;
    localparam int T_FM   = T_SUM + ML;
    localparam int T_ASY  = T_FM + 1;
    localparam int LAT    = fsi_pkg::latency(F);
    localparam int NT     = fsi_pkg::TAYLOR_TERMS;
    localparam int NA     = fsi_pkg::ASYM_TERMS;
    localparam int NC     = fsi_pkg::CORDIC_STEPS;
    localparam int XW     = fsi_pkg::XY_W;
    localparam fsi_pkg::q64_t HALF_PI = fsi_pkg::cordic_angle(0) <<< 1;

    // ------------------------------------------------------------------
    // front end: magnitude and square
    // ------------------------------------------------------------------
    logic        accept;
    logic [31:0] ux_reg;
    logic        neg_reg;
    logic [31:0] ux2_reg;
    logic        neg2_reg;
    logic        asym2_reg;
    logic [63:0] x2_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk)
    begin
        ux_reg    <= x_value[31] ? (32'd0 - x_value) : x_value;
        neg_reg   <= x_value[31];
        x2_reg    <= {32'd0, ux_reg} * {32'd0, ux_reg};
        ux2_reg   <= ux_reg;
        neg2_reg  <= neg_reg;
        asym2_reg <= ({32'd0, ux_reg} >= (64'd3 << F));
    end

    // ------------------------------------------------------------------
    // taylor branch
    // ------------------------------------------------------------------
    logic [63:0]   x2m;
    logic [63:0]   xm;
    fsi_pkg::q64_t w_val;

    assign x2m = x2_reg << (56 - 2 * F);
    assign xm  = {32'd0, ux2_reg} << (56 - F);

    // divide by nine by reciprocal multiplication
    fsi_mulq #(.Q(64)) u_mul_w (
        .clk (clk),
        .a   (fsi_pkg::q64_t'(x2m)),
        .b   (fsi_pkg::RECIP9),
        .p   (w_val)
    );

    fsi_pkg::q64_t u_val;
    fsi_pkg::q64_t x3_val;
    logic [63:0]   x3_d;
    fsi_pkg::q64_t tp_p [NT];
    fsi_pkg::q64_t tp_u [NT];
    fsi_pkg::q64_t tay_prod;
    fsi_pkg::q64_t tay_reg;

    fsi_mulq #(.Q(56)) u_mul_u (.clk(clk), .a(w_val), .b(w_val), .p(u_val));

    fsi_mulq #(.Q(56)) u_mul_x3 (
        .clk (clk),
        .a   (fsi_pkg::q64_t'(xm)),
        .b   (fsi_pkg::q64_t'(x2m)),
        .p   (x3_val)
    );

    fsi_delay #(.W(64), .N(T_P - T_X3)) u_dly_x3 (.clk(clk), .din(x3_val), .dout(x3_d));

    // horner chain over u = (x^2/9)^2
    assign tp_p[0] = fsi_pkg::taylor_coef(NT - 1);
    assign tp_u[0] = u_val;

    for (genvar j = 0; j < NT - 1; j++)
    begin : g_taylor
        fsi_horner_cell #(.Q(56), .COEF(fsi_pkg::taylor_coef(NT - 2 - j))) u_hc (
            .clk   (clk),
            .p_in  (tp_p[j]),
            .u_in  (tp_u[j]),
            .p_out (tp_p[j+1]),
            .u_out (tp_u[j+1])
        );
    end

    fsi_mulq #(.Q(56)) u_mul_tay (
        .clk (clk),
        .a   (tp_p[NT-1]),
        .b   (fsi_pkg::q64_t'(x3_d)),
        .p   (tay_prod)
    );

    always_ff @(posedge clk)
    begin
        tay_reg <= fsi_pkg::round_shift(tay_prod, 26);
    end

    // ------------------------------------------------------------------
    // asymptotic branch: reciprocal of x^2
    // ------------------------------------------------------------------
    logic [63:0] dv_rem [NDIV+1];
    logic [63:0] dv_quo [NDIV+1];
    logic [63:0] dv_den [NDIV+1];

    assign dv_rem[0] = 64'd1;
    assign dv_quo[0] = 64'd0;
    assign dv_den[0] = x2_reg;

    for (genvar j = 0; j < NDIV; j++)
    begin : g_recip
        fsi_div_cell u_dc (
            .clk     (clk),
            .rem_in  (dv_rem[j]),
            .quo_in  (dv_quo[j]),
            .den_in  (dv_den[j]),
            .rem_out (dv_rem[j+1]),
            .quo_out (dv_quo[j+1]),
            .den_out (dv_den[j+1])
        );
    end

    fsi_pkg::q64_t r_val;
    fsi_pkg::q64_t rr_val;
    fsi_pkg::q64_t r2_val;

    assign r_val = fsi_pkg::q64_t'(dv_quo[NDIV]);

    fsi_mulq #(.Q(62)) u_mul_r2 (.clk(clk), .a(r_val), .b(r_val), .p(rr_val));

    assign r2_val = rr_val >>> 16;

    // two asymptotic polynomials in r^2
    fsi_pkg::q64_t pc_p [NA];
    fsi_pkg::q64_t pc_u [NA];
    fsi_pkg::q64_t qs_p [NA];
    fsi_pkg::q64_t qs_u [NA];

    assign pc_p[0] = fsi_pkg::pc_coef(0);
    assign pc_u[0] = r2_val;
    assign qs_p[0] = fsi_pkg::qs_coef(0);
    assign qs_u[0] = r2_val;

    for (genvar j = 0; j < NA - 1; j++)
    begin : g_asym
        fsi_horner_cell #(.Q(46), .COEF(fsi_pkg::pc_coef(j + 1))) u_pc (
            .clk   (clk),
            .p_in  (pc_p[j]),
            .u_in  (pc_u[j]),
            .p_out (pc_p[j+1]),
            .u_out (pc_u[j+1])
        );
        fsi_horner_cell #(.Q(46), .COEF(fsi_pkg::qs_coef(j + 1))) u_qs (
            .clk   (clk),
            .p_in  (qs_p[j]),
            .u_in  (qs_u[j]),
            .p_out (qs_p[j+1]),
            .u_out (qs_u[j+1])
        );
    end

    // ------------------------------------------------------------------
    // range reduction of x^2 by 2/pi
    // ------------------------------------------------------------------
    logic [127:0] two_by_pi;
    logic [63:0]  rd_pp_reg [2][4];
    logic [159:0] rd_row_reg [2];
    logic [191:0] rd_full;
    logic [63:0]  rd_t_reg;

    assign two_by_pi = {fsi_pkg::TWO_BY_PI_HI, fsi_pkg::TWO_BY_PI_LO};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 4; j++)
                rd_pp_reg[i][j] <= x2_reg[32*i +: 32] * two_by_pi[32*j +: 32];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
            rd_row_reg[i] <= {96'd0, rd_pp_reg[i][0]}
                           + ({96'd0, rd_pp_reg[i][1]} << 32)
                           + ({96'd0, rd_pp_reg[i][2]} << 64)
                           + ({96'd0, rd_pp_reg[i][3]} << 96);
    end

    assign rd_full = {32'd0, rd_row_reg[0]} + {rd_row_reg[1], 32'd0};

    always_ff @(posedge clk)
    begin
        rd_t_reg <= rd_full[64+OFF +: 64];
    end

    fsi_pkg::q64_t z_val;
    logic [1:0]    quad_d;

    fsi_mulq #(.Q(62)) u_mul_z (
        .clk (clk),
        .a   (fsi_pkg::q64_t'({2'b00, rd_t_reg[61:0]})),
        .b   (HALF_PI),
        .p   (z_val)
    );

    fsi_delay #(.W(2), .N(T_CR - T_T)) u_dly_quad (
        .clk  (clk),
        .din  (rd_t_reg[63:62]),
        .dout (quad_d)
    );

    // cordic row
    logic signed [XW-1:0] cx [NC+1];
    logic signed [XW-1:0] cy [NC+1];
    fsi_pkg::q64_t        cz [NC+1];

    assign cx[0] = fsi_pkg::CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = z_val;

    for (genvar j = 0; j < NC; j++)
    begin : g_cordic
        fsi_cordic_cell #(.IDX(j)) u_cc (
            .clk   (clk),
            .x_in  (cx[j]),
            .y_in  (cy[j]),
            .z_in  (cz[j]),
            .x_out (cx[j+1]),
            .y_out (cy[j+1]),
            .z_out (cz[j+1])
        );
    end

    // quadrant fold
    logic signed [XW-1:0] cos_next;
    logic signed [XW-1:0] sin_next;
    logic signed [XW-1:0] cos_reg;
    logic signed [XW-1:0] sin_reg;

    always_comb
    begin
        case (fsi_pkg::quad_t'(quad_d))
            fsi_pkg::QUAD_0:
            begin
                cos_next = cx[NC];
                sin_next = cy[NC];
            end
            fsi_pkg::QUAD_1:
            begin
                cos_next = -cy[NC];
                sin_next = cx[NC];
            end
            fsi_pkg::QUAD_2:
            begin
                cos_next = -cx[NC];
                sin_next = -cy[NC];
            end
            default:
            begin
                cos_next = cy[NC];
                sin_next = -cx[NC];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    logic [XW-1:0] cos_d;
    logic [XW-1:0] sin_d;
    fsi_pkg::q64_t cos64;
    fsi_pkg::q64_t sin64;

    fsi_delay #(.W(XW), .N(T_PC - T_CS)) u_dly_cos (.clk(clk), .din(cos_reg), .dout(cos_d));
    fsi_delay #(.W(XW), .N(T_PC - T_CS)) u_dly_sin (.clk(clk), .din(sin_reg), .dout(sin_d));

    assign cos64 = {{(64-XW){cos_d[XW-1]}}, cos_d};
    assign sin64 = {{(64-XW){sin_d[XW-1]}}, sin_d};

    // ------------------------------------------------------------------
    // asymptotic combine
    // ------------------------------------------------------------------
    logic [63:0]   r_d;
    logic [31:0]   ux_r;
    fsi_pkg::q64_t y_val;
    logic [63:0]   y_d;
    fsi_pkg::q64_t a_val;
    logic [63:0]   a_d;
    fsi_pkg::q64_t b1_val;
    fsi_pkg::q64_t b_val;
    fsi_pkg::q64_t sum_reg;
    fsi_pkg::q64_t fm_val;
    fsi_pkg::q64_t asy_reg;

    fsi_delay #(.W(64), .N(T_PC + ML - T_R)) u_dly_r (.clk(clk), .din(r_val), .dout(r_d));
    fsi_delay #(.W(32), .N(NDIV)) u_dly_ux (.clk(clk), .din(ux2_reg), .dout(ux_r));

    fsi_mulq #(.Q(F)) u_mul_y (
        .clk (clk),
        .a   (fsi_pkg::q64_t'({32'd0, ux_r})),
        .b   (r_val),
        .p   (y_val)
    );

    fsi_delay #(.W(64), .N(T_SUM - T_R - ML)) u_dly_y (.clk(clk), .din(y_val), .dout(y_d));

    fsi_mulq #(.Q(30)) u_mul_a (.clk(clk), .a(pc_p[NA-1]), .b(cos64), .p(a_val));
    fsi_mulq #(.Q(30)) u_mul_b1 (.clk(clk), .a(qs_p[NA-1]), .b(sin64), .p(b1_val));
    fsi_mulq #(.Q(62)) u_mul_b (
        .clk (clk),
        .a   (b1_val),
        .b   (fsi_pkg::q64_t'(r_d)),
        .p   (b_val)
    );

    fsi_delay #(.W(64), .N(ML)) u_dly_a (.clk(clk), .din(a_val), .dout(a_d));

    always_ff @(posedge clk)
    begin
        sum_reg <= fsi_pkg::q64_t'(a_d) + b_val;
    end

    fsi_mulq #(.Q(62)) u_mul_fm (
        .clk (clk),
        .a   (sum_reg),
        .b   (fsi_pkg::q64_t'(y_d)),
        .p   (fm_val)
    );

    always_ff @(posedge clk)
    begin
        asy_reg <= fsi_pkg::round_shift(fm_val, 16);
    end

    // ------------------------------------------------------------------
    // branch select, sign, saturation
    // ------------------------------------------------------------------
    logic [63:0]   tay_d;
    logic [1:0]    flag_d;
    fsi_pkg::q64_t res;
    fsi_pkg::q64_t res_clamp;
    logic signed [31:0] s_value_reg;
    logic          used_reg;

    fsi_delay #(.W(64), .N(T_ASY - T_TAY)) u_dly_tay (.clk(clk), .din(tay_reg), .dout(tay_d));
    fsi_delay #(.W(2), .N(T_ASY - T_X2)) u_dly_flag (
        .clk  (clk),
        .din  ({asym2_reg, neg2_reg}),
        .dout (flag_d)
    );

    always_comb
    begin
        if (flag_d[1])
            res = flag_d[0] ? (-asy_reg - fsi_pkg::SQRT_PI_8) : (asy_reg + fsi_pkg::SQRT_PI_8);
        else
            res = flag_d[0] ? -fsi_pkg::q64_t'(tay_d) : fsi_pkg::q64_t'(tay_d);
        if (res > fsi_pkg::S32_MAX)
            res_clamp = fsi_pkg::S32_MAX;
        else if (res < fsi_pkg::S32_MIN)
            res_clamp = fsi_pkg::S32_MIN;
        else
            res_clamp = res;
    end

    always_ff @(posedge clk)
    begin
        s_value_reg <= res_clamp[31:0];
        used_reg    <= flag_d[1];
    end

    // transaction valid pipeline
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], accept};
    end

    assign done            = vld_reg[LAT-1];
    assign s_value         = s_value_reg;
    assign used_asymptotic = used_reg;

endmodule

@@ design/fsi_checker.sv @@
// ----------------------------------------------------------------------------
// fsi_checker
// Port-level checks of transaction timing and branch choice.
// ----------------------------------------------------------------------------
module fsi_checker #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] x_value,
    input logic               done,
    input logic signed [31:0] s_value,
    input logic               used_asymptotic
);

    localparam int LAT = fsi_pkg::latency(INPUT_FRAC_BITS);

    logic [31:0] mag;
    logic        big;

    // |x| >= 3 selects the asymptotic branch
    assign mag = x_value[31] ? (32'd0 - x_value) : x_value;
    assign big = ({1'b0, mag} >= (33'd3 << INPUT_FRAC_BITS));

    // every accepted transaction gives a strobe after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after accepted transaction");

    // no strobe without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a transaction");

    // branch flag matches the argument magnitude
    a_branch: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (used_asymptotic == $past(big, LAT)))
        else $error("branch flag does not match argument");

    // zero argument gives zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(x_value == 32'sd0, LAT)) |-> (s_value == 32'sd0))
        else $error("nonzero result for zero argument");

endmodule

bind fresnel_sine_integral fsi_checker #(.INPUT_FRAC_BITS(INPUT_FRAC_BITS)) u_fsi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .x_value         (x_value),
    .done            (done),
    .s_value         (s_value),
    .used_asymptotic (used_asymptotic)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fresnel_sine_integral: a queue-fed driver, a
// monitor on the done strobe, and a bit-exact fixed-point predictor of S(x)
// covering both the Taylor and the asymptotic branch.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1800;
    localparam int STALL_MAX = 5000;
    localparam int DRAIN     = 87 + 2 * FRAC + 30;

    typedef struct packed {
        logic signed [31:0] s_value;
        logic               used_asymptotic;
    } fresnel_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_value;
    logic               done;
    logic signed [31:0] s_value;
    logic               used_asymptotic;

    logic signed [31:0] arg_q[$];
    fresnel_t           fresnel_q[$];
    int                 sent;
    int                 fails;
    int                 quiet;

    fresnel_sine_integral #(.INPUT_FRAC_BITS(FRAC)) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x_value         (x_value),
        .done            (done),
        .s_value         (s_value),
        .used_asymptotic (used_asymptotic)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // signed product shifted right by q, truncated toward zero, saturating
    function automatic longint fx_mul(input longint a, input longint b, input int q);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] pr;
        logic [63:0]  m;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        pr = ({64'd0, ua} * {64'd0, ub}) >> q;
        m  = (pr > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : pr[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    // magnitude shift rounding half away from zero
    function automatic longint round_mag(input longint v, input int s);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // arctangent of 1/n in Q60 by alternating series
    function automatic longint arctan_inv(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] k;
        longint      acc;
        p   = (64'd1 << 60) / n;
        acc = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0])
                acc = acc - longint'(p / (2 * k + 1));
            else
                acc = acc + longint'(p / (2 * k + 1));
            p = p / n / n;
            k = k + 1;
        end
        return acc;
    endfunction

    // cosine and sine of x^2 in Q30: exact 2/pi reduction then cordic
    function automatic void sincos_sq(input logic [63:0] x2, output longint c,
                                      output longint s);
        logic [191:0] full;
        logic [63:0]  frac_turn;
        logic [1:0]   quad;
        longint       quarter;
        longint       z;
        longint       cx;
        longint       cy;
        longint       nx;
        longint       ang;
        full      = {128'd0, x2} * {64'd0, fsi_pkg::TWO_BY_PI_HI, fsi_pkg::TWO_BY_PI_LO};
        frac_turn = full[98 + 2 * FRAC - 32 +: 64];
        quad      = frac_turn[63:62];
        quarter   = arctan_inv(2) + arctan_inv(3);
        z  = fx_mul(longint'({2'b00, frac_turn[61:0]}), 2 * quarter, 62);
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < 32; i++)
        begin
            ang = (i == 0) ? quarter : arctan_inv(64'd1 << i);
            if (z >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z  = z - ang;
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z  = z + ang;
            end
            cx = nx;
        end
        case (fsi_pkg::quad_t'(quad))
            fsi_pkg::QUAD_0: begin c = cx;  s = cy;  end
            fsi_pkg::QUAD_1: begin c = -cy; s = cx;  end
            fsi_pkg::QUAD_2: begin c = -cx; s = -cy; end
            default:         begin c = cy;  s = -cx; end
        endcase
    endfunction

    // expected S(x) and branch flag for one argument
    function automatic fresnel_t fresnel_sine(input logic signed [31:0] x);
        fresnel_t     r;
        logic [63:0]  ux;
        logic [63:0]  x2;
        logic [127:0] quo;
        longint       coef[17];
        longint       g, w, u, p, x2m, xm;
        longint       rr, r2, pc, qs, c, s, acc, y, t, res;
        ux = x[31] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
        x2 = ux * ux;
        r.used_asymptotic = (x2 >= (64'd9 << (2 * FRAC)));
        if (!r.used_asymptotic)
        begin
            // odd polynomial in x^4/81 times x^3
            g = 64'sd1 <<< 56;
            for (int k = 0; k < 17; k++)
            begin
                coef[k] = k[0] ? -(g / (4 * k + 3)) : g / (4 * k + 3);
                g = (g / ((2 * k + 2) * (2 * k + 3))) * 81;
            end
            x2m = longint'(x2 << (56 - 2 * FRAC));
            xm  = longint'(ux << (56 - FRAC));
            w   = x2m / 9;
            u   = fx_mul(w, w, 56);
            p   = coef[16];
            for (int k = 15; k >= 0; k--)
                p = fx_mul(p, u, 56) + coef[k];
            res = round_mag(fx_mul(p, fx_mul(xm, x2m, 56), 56), 26);
            if (x[31])
                res = -res;
        end
        else
        begin
            // reciprocal of x^2, asymptotic weights, cordic trig
            quo = (128'd1 << (62 + 2 * FRAC)) / {64'd0, x2};
            rr  = longint'(quo[63:0]);
            r2  = fx_mul(rr, rr, 62) >>> 16;
            pc  = -(64'sd2027025 <<< 37);
            pc  = fx_mul(pc, r2, 46) + (64'sd10395 <<< 39);
            pc  = fx_mul(pc, r2, 46) - (64'sd105 <<< 41);
            pc  = fx_mul(pc, r2, 46) + (64'sd3 <<< 43);
            pc  = fx_mul(pc, r2, 46) - (64'sd1 <<< 45);
            qs  = -(64'sd34459425 <<< 36);
            qs  = fx_mul(qs, r2, 46) + (64'sd135135 <<< 38);
            qs  = fx_mul(qs, r2, 46) - (64'sd945 <<< 40);
            qs  = fx_mul(qs, r2, 46) + (64'sd15 <<< 42);
            qs  = fx_mul(qs, r2, 46) - (64'sd1 <<< 44);
            sincos_sq(x2, c, s);
            acc = fx_mul(pc, c, 30) + fx_mul(fx_mul(qs, s, 30), rr, 62);
            y   = fx_mul(longint'(ux), rr, FRAC);
            t   = round_mag(fx_mul(acc, y, 62), 16);
            res = x[31] ? -t - 672867904 : t + 672867904;
        end
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        r.s_value = res[31:0];
        return r;
    endfunction

    // random argument: full range, the Taylor region, a moderate asymptotic one, or one near the branch boundary
    function automatic logic signed [31:0] rand_arg();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom;
            3, 4, 5: v = $urandom_range(196607);
            6, 7:    v = $urandom_range(196608, 100 << FRAC);
            default: v = $urandom_range(196300, 197000);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // driver: issue one transaction per free slot, idle per phase
    always @(posedge clk or negedge rst_n)
    begin
        logic slot;
        logic idle;
        int   pct;
        if (!rst_n)
        begin
            start   <= 1'b0;
            x_value <= '0;
            sent    <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                fresnel_q.push_back(fresnel_sine(x_value));
                sent <= sent + 1;
            end
            slot = !start || !busy;
            pct  = (sent < 700) ? 38 : (sent < 1400) ? 67 : 0;
            idle = ($urandom_range(99) < pct);
            if (slot)
            begin
                if (arg_q.size() != 0 && !idle)
                begin
                    start   <= 1'b1;
                    x_value <= arg_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        fresnel_t e;
        int       bad;
        bad = 0;
        if (rst_n && done)
        begin
            if (fresnel_q.size() == 0)
            begin
                $error("unexpected result s_value=%0d", s_value);
                bad = bad + 1;
            end
            else
            begin
                e = fresnel_q.pop_front();
                if (s_value !== e.s_value)
                begin
                    $error("s_value expected %0d actual %0d", e.s_value, s_value);
                    bad = bad + 1;
                end
                if (used_asymptotic !== e.used_asymptotic)
                begin
                    $error("used_asymptotic expected %0b actual %0b",
                           e.used_asymptotic, used_asymptotic);
                    bad = bad + 1;
                end
            end
        end
        if (bad != 0)
            fails <= fails + bad;
    end

    // watchdog on cycles with no transaction in or out
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_MAX)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [31:0] edge_args[22];
        fails = 0;
        quiet = 0;
        rst_n = 1'b0;
        edge_args = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                      -32'sh7FFF_FFFF, 32'sd196607, 32'sd196608, -32'sd196607,
                      -32'sd196608, 32'sd65536, -32'sd65536, 32'sh0001_921F,
                      32'sd196609, 32'sh0010_0000, -32'sh0100_0000,
                      32'sh4000_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sd131072, 32'sd92682, -32'sd100000};
        foreach (edge_args[i])
            arg_q.push_back(edge_args[i]);
        for (int i = 0; i < N_RANDOM; i++)
            arg_q.push_back(rand_arg());
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (arg_q.size() != 0 || start || fresnel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fails == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ fresnel_sine_integral.f @@
design/fsi_pkg.sv
design/fsi_delay.sv
design/fsi_mulq.sv
design/fsi_horner_cell.sv
design/fsi_div_cell.sv
design/fsi_cordic_cell.sv
design/fresnel_sine_integral.sv
design/fsi_checker.sv
tb/tb.sv
